>>> hw/rtl/lagac_pkg.sv
// Shared constants and controller/datapath interface types for the lagged autocorrelation block.
package lagac_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int LAG_W       = 12;
  localparam int OUT_W       = 32;
  localparam int LAG_RESET   = 1;

  localparam int ADDR_W    = $clog2(MAX_SAMPLES);
  localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int PROD_W    = 2 * SAMPLE_BITS;
  localparam int SUM_W     = PROD_W + ADDR_W;
  localparam int CMP_W     = (LAG_W > CNT_W) ? LAG_W + 1 : CNT_W + 1;
  localparam int SAT_W     = (SUM_W > OUT_W) ? SUM_W : OUT_W + 1;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam logic [SAT_W-1:0] SAT_POS = SAT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [SAT_W-1:0] SAT_NEG = SAT_W'(64'd1 << (OUT_W - 1));

  typedef struct packed {
    logic smp_wr;
    logic close;
    logic walk_issue;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic too_long;
    logic issue_last;
    logic pipe_busy;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/lagac_ram.sv
// Generic RAM: one write port, two registered read ports.
module lagac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a_r <= mem_r[rd_addr_a];
      rd_data_b_r <= mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

>>> hw/rtl/lagac_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lagac_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lagac_pkg::SUM_W-1:0] dividend,
  input  logic [lagac_pkg::CNT_W-1:0] divisor,
  output logic                        busy,
  output logic [lagac_pkg::SUM_W-1:0] quotient
);

  logic                            busy_r;
  logic [lagac_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [lagac_pkg::SUM_W-1:0]     quo_r;
  logic [lagac_pkg::CNT_W:0]       rem_r;
  logic [lagac_pkg::CNT_W-1:0]     dvs_r;

  logic [lagac_pkg::CNT_W:0]       rem_sh;
  logic                            ge;
  logic [lagac_pkg::CNT_W:0]       rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[lagac_pkg::CNT_W-1:0], quo_r[lagac_pkg::SUM_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= lagac_pkg::DIV_CNT_W'(lagac_pkg::SUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == lagac_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // shift the next dividend bit into the remainder, the quotient bit in at the bottom
      quo_r <= {quo_r[lagac_pkg::SUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> hw/rtl/lagac_dp.sv
// Datapath: sample store, lag register, product pipeline, accumulator, divider, output register.
module lagac_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lagac_pkg::cmd_t                   cmd,
  output lagac_pkg::sts_t                   sts,
  input  logic                              cfg_valid,
  input  logic [lagac_pkg::LAG_W-1:0]       cfg_lag_distance,
  input  logic signed [lagac_pkg::SAMPLE_BITS-1:0] sample_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lagac_pkg::OUT_W-1:0] out_mean_product,
  output logic                              out_lag_too_long
);

  logic [lagac_pkg::LAG_W-1:0]  lag_r;
  logic [lagac_pkg::CNT_W-1:0]  count_r;
  logic                         too_long_r;
  logic [lagac_pkg::CNT_W-1:0]  pairs_r;
  logic [lagac_pkg::CNT_W-1:0]  idx_a_r;
  logic [lagac_pkg::CNT_W-1:0]  idx_b_r;
  logic                         v1_r;
  logic                         v2_r;
  logic signed [lagac_pkg::PROD_W-1:0] prod_r;
  logic signed [lagac_pkg::SUM_W-1:0]  sum_r;
  logic                         neg_r;
  logic [lagac_pkg::OUT_W-1:0]  mean_r;
  logic                         flag_r;
  logic                         out_valid_r;

  logic                               full;
  logic [lagac_pkg::CNT_W-1:0]        count_after;
  logic [lagac_pkg::CMP_W-1:0]        lag_ext;
  logic [lagac_pkg::CMP_W-1:0]        cnt_ext;
  logic [lagac_pkg::CMP_W-1:0]        pairs_ext;
  logic                               too_long_cmb;
  logic [lagac_pkg::SAMPLE_BITS-1:0]  ram_a;
  logic [lagac_pkg::SAMPLE_BITS-1:0]  ram_b;
  logic [lagac_pkg::SUM_W-1:0]        dividend;
  logic                               div_busy;
  logic [lagac_pkg::SUM_W-1:0]        quotient;
  logic [lagac_pkg::SAT_W-1:0]        q_ext;
  logic [lagac_pkg::SAT_W-1:0]        neg_mag;
  logic [lagac_pkg::OUT_W-1:0]        result;

  always_comb begin
    full         = count_r == lagac_pkg::CNT_W'(lagac_pkg::MAX_SAMPLES);
    count_after  = full ? count_r : count_r + 1'b1;
    lag_ext      = lagac_pkg::CMP_W'(lag_r);
    cnt_ext      = lagac_pkg::CMP_W'(count_after);
    too_long_cmb = lag_ext >= cnt_ext;
    pairs_ext    = cnt_ext - lag_ext;
  end

  lagac_ram #(
    .WIDTH (lagac_pkg::SAMPLE_BITS),
    .DEPTH (lagac_pkg::MAX_SAMPLES)
  ) u_ram (
    .clk       (clk),
    .wr_en     (cmd.smp_wr && !full),
    .wr_addr   (count_r[lagac_pkg::ADDR_W-1:0]),
    .wr_data   (sample_value),
    .rd_en     (cmd.walk_issue),
    .rd_addr_a (idx_a_r[lagac_pkg::ADDR_W-1:0]),
    .rd_addr_b (idx_b_r[lagac_pkg::ADDR_W-1:0]),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  // lag register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r <= lagac_pkg::LAG_W'(lagac_pkg::LAG_RESET);
    end else if (cfg_valid) begin
      lag_r <= cfg_lag_distance;
    end
  end

  // fill count, drop samples once the store is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.close) begin
      count_r <= '0;
    end else if (cmd.smp_wr && !full) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.walk_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      too_long_r <= too_long_cmb;
      pairs_r    <= pairs_ext[lagac_pkg::CNT_W-1:0];
      idx_a_r    <= '0;
      idx_b_r    <= lag_ext[lagac_pkg::CNT_W-1:0];
    end else if (cmd.walk_issue) begin
      idx_a_r <= idx_a_r + 1'b1;
      idx_b_r <= idx_b_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= $signed(ram_a) * $signed(ram_b);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close) begin
      sum_r <= '0;
    end else if (v2_r) begin
      sum_r <= sum_r + lagac_pkg::SUM_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= sum_r[lagac_pkg::SUM_W-1];
    end
  end

  assign dividend = sum_r[lagac_pkg::SUM_W-1] ? lagac_pkg::SUM_W'(-sum_r)
                                              : lagac_pkg::SUM_W'(sum_r);

  lagac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (pairs_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // saturate the quotient magnitude, then restore the sign
  always_comb begin
    q_ext   = lagac_pkg::SAT_W'(quotient);
    neg_mag = (q_ext > lagac_pkg::SAT_NEG) ? lagac_pkg::SAT_NEG : q_ext;
    if (neg_r) begin
      result = lagac_pkg::OUT_W'(0) - neg_mag[lagac_pkg::OUT_W-1:0];
    end else if (q_ext > lagac_pkg::SAT_POS) begin
      result = lagac_pkg::SAT_POS[lagac_pkg::OUT_W-1:0];
    end else begin
      result = q_ext[lagac_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_r <= too_long_r ? '0 : result;
      flag_r <= too_long_r;
    end
  end

  always_comb begin
    sts.too_long   = too_long_r;
    sts.issue_last = lagac_pkg::CNT_W'(idx_a_r + 1'b1) == pairs_r;
    sts.pipe_busy  = v1_r || v2_r;
    sts.div_busy   = div_busy;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_mean_product = $signed(mean_r);
  assign out_lag_too_long = flag_r;

endmodule

>>> hw/rtl/lagac_ctrl.sv
// Controller: sequences load, walk, drain, divide and result hand-off.
module lagac_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_block_end,
  output logic            in_stall,
  input  lagac_pkg::sts_t sts,
  output lagac_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_WALK,
    S_DRAIN,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        cmd.smp_wr = in_valid;
        cmd.close  = in_valid && in_block_end;
        if (in_valid && in_block_end) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = sts.too_long ? S_OUT : S_WALK;
      end
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the last product to reach the accumulator
        if (!sts.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_LOAD;

endmodule

>>> hw/rtl/lag_autocorrelation.sv
// Top level of the lagged autocorrelation block.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_sample_value[15:0] s, in_block_end
//   out_     output     out_valid/out_stall out_mean_product[31:0] s, out_lag_too_long
//   cfg_     input      cfg_valid/cfg_ready cfg_lag_distance[11:0]
//
// Samples load one item per cycle while in_stall is low into a 4096-entry, two-read-port RAM.
// After the block-end item: a check state, then P pairs read, multiplied and accumulated
// (P = count - lag), a drain of the product pipe, the divider
// (44 quotient bits, one per cycle), then the output load; a too-long lag skips to the load.
// in_stall is high from block end until the result is loaded into the output register.
// Reset is synchronous; the store needs no clearing, count and lag reset at once.
module lag_autocorrelation (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [lagac_pkg::SAMPLE_BITS-1:0]  in_sample_value,
  input  logic                                      in_block_end,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [lagac_pkg::OUT_W-1:0]        out_mean_product,
  output logic                                      out_lag_too_long,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [lagac_pkg::LAG_W-1:0]               cfg_lag_distance
);

  lagac_pkg::cmd_t cmd;
  lagac_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  lagac_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_block_end (in_block_end),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  lagac_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_lag_distance (cfg_lag_distance),
    .sample_value     (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mean_product (out_mean_product),
    .out_lag_too_long (out_lag_too_long)
  );

endmodule

>>> dv/tb_lag_autocorrelation.sv
// Self-checking testbench for the lagged autocorrelation block: directed table, lag-edge blocks, then random blocks.
`timescale 1ns / 1ps

module tb_lag_autocorrelation;

  localparam int SW          = lagac_pkg::SAMPLE_BITS;
  localparam int OW          = lagac_pkg::OUT_W;
  localparam int LW          = lagac_pkg::LAG_W;
  localparam int DEPTH       = lagac_pkg::MAX_SAMPLES;
  localparam int SETTLE      = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_TARGET = 590;

  typedef struct packed {
    logic [SW-1:0] smp;
    logic          last;
    logic          pinned;
    logic [OW-1:0] mean;
    logic          too_long;
  } stim_row_t;

  typedef struct packed {
    logic [OW-1:0] mean;
    logic          too_long;
  } lag_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [SW-1:0] in_sample_value;
  logic                 in_block_end;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [OW-1:0] out_mean_product;
  logic                 out_lag_too_long;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LW-1:0]        cfg_lag_distance;

  // Predictor state
  logic signed [SW-1:0] sample_ram [0:DEPTH-1];
  int                   stored_n = 0;
  logic [LW-1:0]        lag_sel  = LW'(lagac_pkg::LAG_RESET);

  lag_result_t pending_means [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          rand_items  = 0;
  bit          no_idle     = 0;

  // Reset lag is 1; expectations typed in where they are obvious.
  localparam int N_DIRECTED = 16;
  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{16'h7FFF, 1'b1, 1'b1, 32'h0000_0000, 1'b1},  // single sample, lag too long
    '{16'h8000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'h8000, 1'b1, 1'b1, 32'h4000_0000, 1'b0},  // most negative squared
    '{16'h7FFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'h8000, 1'b1, 1'b1, 32'hC000_8000, 1'b0},  // max times min
    '{16'h1000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'h1000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'h1000, 1'b1, 1'b1, 32'h0100_0000, 1'b0},  // 1.0 * 1.0
    '{16'h0001, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},  // -1/2 truncates toward zero
    '{16'h1234, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'hA5A5, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'h0F0F, 1'b1, 1'b0, 32'h0, 1'b0},
    '{16'h7FFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{16'h7FFF, 1'b1, 1'b1, 32'h3FFF_0001, 1'b0}   // max squared
  };

  lag_autocorrelation uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .in_block_end     (in_block_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mean_product (out_mean_product),
    .out_lag_too_long (out_lag_too_long),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_lag_distance (cfg_lag_distance)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_lag_autocorrelation NOT OK");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    if ($urandom_range(0, 9) != 0) return SW'($urandom);
    case ($urandom_range(0, 4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [OW-1:0] got,
                                 input logic [OW-1:0] want);
    $display("ERROR @%0t %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Store the sample and, on block end, form the mean lagged product.
  task automatic absorb_item(input stim_row_t row);
    lag_result_t res;
    longint      pair_sum;
    longint      q;
    int          pairs;
    if (stored_n < DEPTH) begin
      sample_ram[stored_n] = row.smp;
      stored_n++;
    end
    if (row.last) begin
      pair_sum = 0;
      if (int'(lag_sel) >= stored_n) begin
        res.mean     = '0;
        res.too_long = 1'b1;
      end else begin
        pairs = stored_n - int'(lag_sel);
        for (int i = 0; i < pairs; i++)
          pair_sum += longint'(sample_ram[i]) * longint'(sample_ram[i + int'(lag_sel)]);
        q = pair_sum / longint'(pairs);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        else if (q < -64'sd2147483648) q = -64'sd2147483648;
        res.mean     = q[OW-1:0];
        res.too_long = 1'b0;
      end
      if (row.pinned) begin
        res.mean     = row.mean;
        res.too_long = row.too_long;
      end
      pending_means = {pending_means, res};
      stored_n = 0;
    end
  endtask

  task automatic send_item(input stim_row_t row, input int gap);
    in_valid        <= 1'b1;
    in_sample_value <= row.smp;
    in_block_end    <= row.last;
    do @(posedge clk); while (in_stall);
    absorb_item(row);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_block(input int len, input bit use_fixed, input logic [SW-1:0] fixed_val);
    stim_row_t row;
    row = '0;
    for (int k = 0; k < len; k++) begin
      row.smp  = use_fixed ? fixed_val : rand_sample();
      row.last = (k == len - 1);
      send_item(row, idle_len());
    end
  endtask

  // Hold off the sender until every result is in, then let the block settle.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    wait (pending_means.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_lag(input logic [LW-1:0] v);
    cfg_valid        <= 1'b1;
    cfg_lag_distance <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lag_sel = v;
  endtask

  initial begin : result_stall
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = idle_len();
      out_stall <= (n > 0);
      repeat (n > 0 ? n : $urandom_range(1, 8)) @(posedge clk);
      if (n > 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_result
    lag_result_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_means.size() == 0) begin
        report_mismatch("result with nothing pending", out_mean_product, '0);
      end else begin
        head = pending_means.pop_front();
        if (out_mean_product !== head.mean)
          report_mismatch("mean_product", out_mean_product, head.mean);
        if (out_lag_too_long !== head.too_long)
          report_mismatch("lag_too_long", OW'(out_lag_too_long), OW'(head.too_long));
      end
    end
  end

  initial begin : stimulus
    int r;
    int len;
    int nblocks;
    logic [LW-1:0] lag_pick;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_sample_value  <= '0;
    in_block_end     <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_lag_distance <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_DIRECTED; k++)
      send_item(directed_rows[k], idle_len());
    drain();

    // Lag 0 over a run of most-negative samples, then the largest lag on a short block.
    no_idle = 1;
    write_lag('0);
    run_block(40, 1'b1, 16'h8000);
    drain();
    write_lag('1);
    run_block(3, 1'b0, '0);
    drain();

    while (rand_items < RAND_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 15)      lag_pick = '0;
      else if (r < 25) lag_pick = '1;
      else if (r < 85) lag_pick = LW'($urandom_range(1, 12));
      else             lag_pick = LW'($urandom);
      write_lag(lag_pick);
      nblocks = $urandom_range(2, 8);
      repeat (nblocks) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 150);
        run_block(len, 1'b0, '0);
        rand_items += len;
      end
      drain();
    end

    if (mismatches == 0)
      $display("tb_lag_autocorrelation OK");
    else
      $display("tb_lag_autocorrelation NOT OK");
    $finish;
  end

endmodule

>>> lag_autocorrelation.f
hw/rtl/lagac_pkg.sv
hw/rtl/lagac_ram.sv
hw/rtl/lagac_div.sv
hw/rtl/lagac_dp.sv
hw/rtl/lagac_ctrl.sv
hw/rtl/lag_autocorrelation.sv
dv/tb_lag_autocorrelation.sv
